[rtl/tfrrt_pkg.sv]
// Package for the text frame reassembly and read tracker.
// Constants, types and small helper functions; no dependencies.
`default_nettype none
package tfrrt_pkg;

  localparam int PENDING_DEPTH = 32;
  localparam int TEXT_FRAMES   = 4;
  localparam int BUF_WORDS     = 4;
  localparam int IDX_W         = 2;
  localparam int PTR_W         = $clog2(PENDING_DEPTH);
  localparam int CNT_W         = $clog2(PENDING_DEPTH + 1);
  localparam int LEN_W         = 6;

  localparam logic [10:0] BASE_ID_RST = 11'h220;
  localparam logic [10:0] END_ID_RST  = 11'h225;
  localparam logic [15:0] TIMEOUT_RST = 16'd5000;

  localparam logic [1:0] REG_BASE_ID = 2'd0;
  localparam logic [1:0] REG_END_ID  = 2'd1;
  localparam logic [1:0] REG_TIMEOUT = 2'd2;

  typedef enum logic [1:0] {
    CMD_FRAME, CMD_READ_REQ, CMD_SEND, CMD_TIMEOUT
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_DISP, ST_TRIM, ST_EMIT, ST_STAT, ST_TREAD, ST_TCMP
  } state_t;

  typedef enum logic [1:0] {
    PK_TEXT, PK_END_BUF, PK_END_EMPTY, PK_ERR
  } pk_t;

  typedef struct packed {
    logic             we;
    logic [PTR_W-1:0] waddr;
    logic [31:0]      wdata;
    logic [PTR_W-1:0] raddr;
  } ring_req_t;

  typedef struct packed {
    logic        is_packet;
    logic        flag_text;
    logic        flag_end;
    logic        flag_read_error;
    logic [7:0]  packet_seq;
    logic [7:0]  chunk_number;
    logic [5:0]  payload_bytes;
    logic [1:0]  word_number;
    logic [63:0] payload_word;
    logic        frame_consumed;
    logic        read_requested;
    logic        last;
  } out_t;

  function automatic logic [PTR_W-1:0] next_ptr(logic [PTR_W-1:0] p);
    return (p == PTR_W'(PENDING_DEPTH - 1)) ? '0 : p + PTR_W'(1);
  endfunction

  // length of the run of received frames from frame zero
  function automatic logic [LEN_W-1:0] contig_len(logic [BUF_WORDS-1:0] m);
    logic [LEN_W-1:0] l;
    logic             run;
    l   = '0;
    run = 1'b1;
    for (int i = 0; i < TEXT_FRAMES; i++) begin
      run = run & m[i];
      if (run) l = l + LEN_W'(8);
    end
    return l;
  endfunction

endpackage
`default_nettype wire

[rtl/tfrrt_in_if.sv]
// Input channel of the text frame reassembly and read tracker.
// Valid/ready handshake with the event word; no dependencies.
`default_nettype none
interface tfrrt_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  cmd;
  logic [10:0] frame_id;
  logic [63:0] frame_data;
  logic [31:0] now_ms;
  modport source(output valid, cmd, frame_id, frame_data, now_ms, input ready);
  modport sink(input valid, cmd, frame_id, frame_data, now_ms, output ready);
endinterface
`default_nettype wire

[rtl/tfrrt_out_if.sv]
// Result channel of the text frame reassembly and read tracker.
// Valid/ready handshake with the result word; no dependencies.
`default_nettype none
interface tfrrt_out_if;
  logic        valid;
  logic        ready;
  logic        is_packet;
  logic        flag_text;
  logic        flag_end;
  logic        flag_read_error;
  logic [7:0]  packet_seq;
  logic [7:0]  chunk_number;
  logic [5:0]  payload_bytes;
  logic [1:0]  word_number;
  logic [63:0] payload_word;
  logic        frame_consumed;
  logic        read_requested;
  logic        last;
  modport source(output valid, is_packet, flag_text, flag_end, flag_read_error, packet_seq,
                 chunk_number, payload_bytes, word_number, payload_word, frame_consumed,
                 read_requested, last, input ready);
  modport sink(input valid, is_packet, flag_text, flag_end, flag_read_error, packet_seq,
               chunk_number, payload_bytes, word_number, payload_word, frame_consumed,
               read_requested, last, output ready);
endinterface
`default_nettype wire

[rtl/tfrrt_ring.sv]
// Ring of pending request send times: one write port, one registered read port.
// Depends on tfrrt_pkg.
`default_nettype none
module tfrrt_ring (
  input  wire logic                 clk,
  input  wire tfrrt_pkg::ring_req_t req,
  output logic [31:0]               rd_data
);
  import tfrrt_pkg::*;

  logic [31:0] mem [PENDING_DEPTH];
  logic [31:0] rd_r;

  always_ff @(posedge clk) begin
    if (req.we) mem[req.waddr] <= req.wdata;
    rd_r <= mem[req.raddr];
  end

  assign rd_data = rd_r;
endmodule
`default_nettype wire

[rtl/text_frame_reassembly_read_tracker_unit.sv]
// Text frame reassembly and read tracker, top level.
// Depends on tfrrt_pkg, tfrrt_in_if, tfrrt_out_if and tfrrt_ring.
//
// One event word is taken at a time; in_ch.ready is high only while the unit is idle.
// Each event is dispatched and ends with a status word, after any packet words; each
// result waits while the output register is still held. An end frame with buffered
// text first trims trailing zero bytes (up to 32) from its length. The timeout check
// walks the timestamp ring from the oldest entry, a registered ring read and an age
// compare per entry plus a timed-out entry's error packet words; it stops at the first
// entry still in time or when the ring is empty. An output register parts the result
// side from the sequencer, so a result may wait there while the next event is worked.
`default_nettype none
module text_frame_reassembly_read_tracker_unit (
  input  wire logic        clk,
  input  wire logic        rst_n,
  tfrrt_in_if.sink         in_ch,
  tfrrt_out_if.source      out_ch,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);
  import tfrrt_pkg::*;

  state_t state_r, state_nxt;
  pk_t    pk_r, pk_nxt;

  logic [10:0] base_id_r, end_id_r;
  logic [15:0] timeout_r;
  logic [1:0]  cmd_r, cmd_nxt;
  logic [10:0] id_r, id_nxt;
  logic [63:0] data_r, data_nxt;
  logic [31:0] now_r, now_nxt;

  logic [63:0]          buf_r [BUF_WORDS];
  logic [63:0]          buf_nxt [BUF_WORDS];
  logic [BUF_WORDS-1:0] mask_r, mask_nxt;
  logic [7:0]           chunk_r, chunk_nxt, seq_r, seq_nxt;
  logic [CNT_W-1:0]     queued_r, queued_nxt, count_r, count_nxt;
  logic [PTR_W-1:0]     head_r, head_nxt, tail_r, tail_nxt;
  logic [LEN_W-1:0]     len_r, len_nxt;
  logic [1:0]           word_r, word_nxt;
  logic                 consumed_r, consumed_nxt, requested_r, requested_nxt;

  logic ov_r, ov_nxt;
  out_t od_r, od_nxt;

  ring_req_t   ring_req;
  logic [31:0] ring_rd;

  logic             in_acc, out_free, is_text, is_end, last_word, timed_out;
  logic [11:0]      diff;
  logic [IDX_W-1:0] idx;
  logic [LEN_W-1:0] lm1;
  logic [7:0]       trim_byte;
  logic [31:0]      age;

  tfrrt_ring u_ring (
    .clk     (clk),
    .req     (ring_req),
    .rd_data (ring_rd)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_acc      = in_ch.valid && in_ch.ready;
  assign out_free    = !ov_r || out_ch.ready;

  assign diff      = {1'b0, id_r} - {1'b0, base_id_r};
  assign is_text   = (id_r >= base_id_r) && (diff < 12'(TEXT_FRAMES));
  assign idx       = diff[IDX_W-1:0];
  assign is_end    = (id_r == end_id_r);
  assign lm1       = len_r - LEN_W'(1);
  assign last_word = (len_r == '0) || (word_r == lm1[4:3]);
  assign trim_byte = buf_r[lm1[4:3]][{lm1[2:0], 3'b000} +: 8];
  assign age       = now_r - ring_rd;
  assign timed_out = age > {16'd0, timeout_r};

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ST_DISP;
      ST_DISP: begin
        case (cmd_t'(cmd_r))
          CMD_FRAME: begin
            if (is_text) state_nxt = (idx == '0 && mask_r != '0) ? ST_EMIT : ST_STAT;
            else if (is_end) state_nxt = (mask_r != '0) ? ST_TRIM : ST_EMIT;
            else state_nxt = ST_STAT;
          end
          CMD_READ_REQ: begin
            state_nxt = (queued_r >= CNT_W'(PENDING_DEPTH)) ? ST_EMIT : ST_STAT;
          end
          CMD_SEND: begin
            state_nxt = (queued_r != '0 && count_r >= CNT_W'(PENDING_DEPTH)) ?
                        ST_EMIT : ST_STAT;
          end
          CMD_TIMEOUT: state_nxt = ST_TREAD;
          default:     state_nxt = ST_STAT;
        endcase
      end
      ST_TRIM: if (len_r == '0 || trim_byte != 8'd0) state_nxt = ST_EMIT;
      ST_EMIT: begin
        if (out_free && last_word) begin
          state_nxt = (pk_r == PK_ERR && cmd_t'(cmd_r) == CMD_TIMEOUT) ? ST_TREAD : ST_STAT;
        end
      end
      ST_STAT:  if (out_free) state_nxt = ST_IDLE;
      ST_TREAD: state_nxt = (count_r == '0) ? ST_STAT : ST_TCMP;
      ST_TCMP:  state_nxt = timed_out ? ST_EMIT : ST_STAT;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and outputs
  always_comb begin
    cmd_nxt       = cmd_r;
    id_nxt        = id_r;
    data_nxt      = data_r;
    now_nxt       = now_r;
    buf_nxt       = buf_r;
    mask_nxt      = mask_r;
    chunk_nxt     = chunk_r;
    seq_nxt       = seq_r;
    queued_nxt    = queued_r;
    count_nxt     = count_r;
    head_nxt      = head_r;
    tail_nxt      = tail_r;
    len_nxt       = len_r;
    word_nxt      = word_r;
    pk_nxt        = pk_r;
    consumed_nxt  = consumed_r;
    requested_nxt = requested_r;
    ov_nxt        = ov_r && !out_ch.ready;
    od_nxt        = od_r;
    ring_req.we    = 1'b0;
    ring_req.waddr = tail_r;
    ring_req.wdata = now_r;
    ring_req.raddr = head_r;

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cmd_nxt       = in_ch.cmd;
          id_nxt        = in_ch.frame_id;
          data_nxt      = in_ch.frame_data;
          now_nxt       = in_ch.now_ms;
          consumed_nxt  = 1'b0;
          requested_nxt = 1'b0;
        end
      end
      ST_DISP: begin
        word_nxt = '0;
        case (cmd_t'(cmd_r))
          CMD_FRAME: begin
            if (is_text) begin
              consumed_nxt = 1'b1;
              if (idx == '0 && mask_r != '0) begin
                pk_nxt  = PK_TEXT;
                len_nxt = contig_len(mask_r);
              end else begin
                buf_nxt[idx]  = data_r;
                mask_nxt[idx] = 1'b1;
              end
            end else if (is_end) begin
              consumed_nxt = 1'b1;
              if (mask_r != '0) begin
                pk_nxt  = PK_END_BUF;
                len_nxt = contig_len(mask_r);
              end else begin
                pk_nxt  = PK_END_EMPTY;
                len_nxt = '0;
              end
            end
          end
          CMD_READ_REQ: begin
            if (queued_r >= CNT_W'(PENDING_DEPTH)) begin
              pk_nxt  = PK_ERR;
              len_nxt = '0;
            end else begin
              queued_nxt = queued_r + CNT_W'(1);
            end
          end
          CMD_SEND: begin
            if (queued_r != '0) begin
              requested_nxt = 1'b1;
              queued_nxt    = queued_r - CNT_W'(1);
              if (count_r == '0) begin
                for (int i = 0; i < BUF_WORDS; i++) buf_nxt[i] = '0;
                mask_nxt  = '0;
                chunk_nxt = '0;
              end
              if (count_r >= CNT_W'(PENDING_DEPTH)) begin
                pk_nxt  = PK_ERR;
                len_nxt = '0;
              end else begin
                ring_req.we = 1'b1;
                tail_nxt    = next_ptr(tail_r);
                count_nxt   = count_r + CNT_W'(1);
              end
            end
          end
          default: ;
        endcase
      end
      ST_TRIM: begin
        if (len_r != '0 && trim_byte == 8'd0) len_nxt = lm1;
      end
      ST_TCMP: begin
        word_nxt = '0;
        if (timed_out) begin
          pk_nxt  = PK_ERR;
          len_nxt = '0;
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt                 = 1'b1;
          od_nxt                 = '0;
          od_nxt.is_packet       = 1'b1;
          od_nxt.flag_text       = (pk_r != PK_ERR);
          od_nxt.flag_end        = (pk_r == PK_END_BUF) || (pk_r == PK_END_EMPTY);
          od_nxt.flag_read_error = (pk_r == PK_ERR);
          od_nxt.packet_seq      = seq_r;
          od_nxt.chunk_number    = (pk_r == PK_ERR) ? 8'd0 : chunk_r;
          od_nxt.payload_bytes   = len_r;
          od_nxt.word_number     = word_r;
          od_nxt.payload_word    = (len_r == '0) ? 64'd0 : buf_r[word_r];
          if (!last_word) begin
            word_nxt = word_r + 2'd1;
          end else begin
            seq_nxt = seq_r + 8'd1;
            for (int i = 0; i < BUF_WORDS; i++) buf_nxt[i] = '0;
            mask_nxt = '0;
            case (pk_r)
              PK_TEXT: begin
                chunk_nxt     = chunk_r + 8'd1;
                buf_nxt[idx]  = data_r;
                mask_nxt[idx] = 1'b1;
              end
              PK_END_BUF, PK_END_EMPTY: begin
                if (pk_r == PK_END_EMPTY) begin
                  buf_nxt  = buf_r;
                  mask_nxt = mask_r;
                end
                chunk_nxt = '0;
                if (count_r != '0) begin
                  head_nxt  = next_ptr(head_r);
                  count_nxt = count_r - CNT_W'(1);
                end
              end
              default: begin
                chunk_nxt = '0;
                if (cmd_t'(cmd_r) == CMD_SEND) begin
                  // full ring: oldest out, new send time in
                  head_nxt    = next_ptr(head_r);
                  ring_req.we = 1'b1;
                  tail_nxt    = next_ptr(tail_r);
                end else if (cmd_t'(cmd_r) == CMD_TIMEOUT) begin
                  head_nxt  = next_ptr(head_r);
                  count_nxt = count_r - CNT_W'(1);
                end
              end
            endcase
          end
        end
      end
      ST_STAT: begin
        if (out_free) begin
          ov_nxt                = 1'b1;
          od_nxt                = '0;
          od_nxt.frame_consumed = consumed_r;
          od_nxt.read_requested = requested_r;
          od_nxt.last           = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      base_id_r <= BASE_ID_RST;
      end_id_r  <= END_ID_RST;
      timeout_r <= TIMEOUT_RST;
      for (int i = 0; i < BUF_WORDS; i++) buf_r[i] <= '0;
      mask_r    <= '0;
      chunk_r   <= '0;
      seq_r     <= '0;
      queued_r  <= '0;
      count_r   <= '0;
      head_r    <= '0;
      tail_r    <= '0;
      ov_r      <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      buf_r    <= buf_nxt;
      mask_r   <= mask_nxt;
      chunk_r  <= chunk_nxt;
      seq_r    <= seq_nxt;
      queued_r <= queued_nxt;
      count_r  <= count_nxt;
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      ov_r     <= ov_nxt;
      if (cfg_we) begin
        case (cfg_index)
          REG_BASE_ID: base_id_r <= cfg_data[10:0];
          REG_END_ID:  end_id_r  <= cfg_data[10:0];
          REG_TIMEOUT: timeout_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    cmd_r       <= cmd_nxt;
    id_r        <= id_nxt;
    data_r      <= data_nxt;
    now_r       <= now_nxt;
    len_r       <= len_nxt;
    word_r      <= word_nxt;
    pk_r        <= pk_nxt;
    consumed_r  <= consumed_nxt;
    requested_r <= requested_nxt;
    od_r        <= od_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.is_packet       = od_r.is_packet;
  assign out_ch.flag_text       = od_r.flag_text;
  assign out_ch.flag_end        = od_r.flag_end;
  assign out_ch.flag_read_error = od_r.flag_read_error;
  assign out_ch.packet_seq      = od_r.packet_seq;
  assign out_ch.chunk_number    = od_r.chunk_number;
  assign out_ch.payload_bytes   = od_r.payload_bytes;
  assign out_ch.word_number     = od_r.word_number;
  assign out_ch.payload_word    = od_r.payload_word;
  assign out_ch.frame_consumed  = od_r.frame_consumed;
  assign out_ch.read_requested  = od_r.read_requested;
  assign out_ch.last            = od_r.last;
endmodule
`default_nettype wire

[bench/tfrrt_checker.sv]
// Checker for the text frame reassembly and read tracker: watches both channels and
// the register port, predicts each result word and compares. Depends on tfrrt_pkg,
// tfrrt_in_if and tfrrt_out_if.
module tfrrt_checker (
  input  logic        clk,
  input  logic        rst_n,
  tfrrt_in_if         in_m,
  tfrrt_out_if        out_m,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          fail_count,
  output int          words_waiting,
  output int          words_checked
);
  import tfrrt_pkg::*;

  logic [10:0] base_id, end_id;
  logic [15:0] timeout_lim;
  logic [63:0] text_buf [4];
  logic [3:0]  rx_mask;
  logic [7:0]  chunk_cnt, seq_cnt;
  logic [5:0]  req_cnt, ring_cnt;
  logic [4:0]  ring_head, ring_tail;
  logic [31:0] send_stamp [32];
  out_t        expected_words [$];

  task automatic clear_text(input bit chunk_too);
    for (int i = 0; i < 4; i++) text_buf[i] = '0;
    rx_mask = '0;
    if (chunk_too) chunk_cnt = '0;
  endtask

  task automatic push_packet(input bit txt, input bit fend, input bit ferr,
                             input logic [7:0] chunk, input int len);
    out_t w;
    int nwords;
    nwords = (len == 0) ? 1 : (len + 7) / 8;
    for (int i = 0; i < nwords && i < 4; i++) begin
      w = '0;
      w.is_packet       = 1'b1;
      w.flag_text       = txt;
      w.flag_end        = fend;
      w.flag_read_error = ferr;
      w.packet_seq      = seq_cnt;
      w.chunk_number    = chunk;
      w.payload_bytes   = len[5:0];
      w.word_number     = i[1:0];
      w.payload_word    = (len == 0) ? '0 : text_buf[i];
      expected_words.push_back(w);
    end
    seq_cnt++;
  endtask

  function automatic int text_length(input bit trim);
    int len, b;
    len = 0;
    for (int i = 0; i < TEXT_FRAMES; i++) begin
      if (!rx_mask[i]) break;
      len += 8;
    end
    if (trim)
      while (len > 0) begin
        b = len - 1;
        if (text_buf[b >> 3][(b & 7) * 8 +: 8] != 8'h00) break;
        len--;
      end
    return len;
  endfunction

  task automatic flush_text(input bit fend);
    push_packet(1'b1, fend, 1'b0, chunk_cnt, text_length(fend));
    chunk_cnt++;
    clear_text(1'b0);
    if (fend) chunk_cnt = '0;
  endtask

  task automatic read_error();
    push_packet(1'b0, 1'b0, 1'b1, 8'd0, 0);
    clear_text(1'b1);
  endtask

  task automatic retire_oldest();
    if (ring_cnt != 0) begin
      ring_head = (ring_head == 5'd31) ? 5'd0 : ring_head + 5'd1;
      ring_cnt--;
    end
  endtask

  task automatic predict_word(input cmd_t cmd, input logic [10:0] fid,
                              input logic [63:0] fdata, input logic [31:0] now);
    out_t st;
    int   slot;
    logic [31:0] age;
    st = '0;
    st.last = 1'b1;
    case (cmd)
      CMD_FRAME: begin
        if (int'(fid) >= int'(base_id) && int'(fid) < int'(base_id) + TEXT_FRAMES) begin
          slot = int'(fid) - int'(base_id);
          if (slot == 0 && rx_mask != 0) flush_text(1'b0);
          text_buf[slot] = fdata;
          rx_mask[slot] = 1'b1;
          st.frame_consumed = 1'b1;
        end else if (fid == end_id) begin
          if (rx_mask != 0) flush_text(1'b1);
          else begin
            push_packet(1'b1, 1'b1, 1'b0, chunk_cnt, 0);
            chunk_cnt = '0;
          end
          retire_oldest();
          st.frame_consumed = 1'b1;
        end
      end
      CMD_READ_REQ: begin
        if (req_cnt >= PENDING_DEPTH) read_error();
        else req_cnt++;
      end
      CMD_SEND: begin
        if (req_cnt > 0) begin
          st.read_requested = 1'b1;
          req_cnt--;
          if (ring_cnt == 0) clear_text(1'b1);
          if (ring_cnt >= PENDING_DEPTH) begin
            read_error();
            retire_oldest();
          end
          send_stamp[ring_tail] = now;
          ring_tail = (ring_tail == 5'd31) ? 5'd0 : ring_tail + 5'd1;
          ring_cnt++;
        end
      end
      default: begin
        while (ring_cnt > 0) begin
          age = now - send_stamp[ring_head];
          if (age <= {16'd0, timeout_lim}) break;
          read_error();
          retire_oldest();
        end
      end
    endcase
    expected_words.push_back(st);
  endtask

  task automatic check_field(input string name, input logic [63:0] exp_v,
                             input logic [63:0] act_v, inout bit bad);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
      bad = 1'b1;
    end
  endtask

  task automatic compare_word();
    out_t e;
    bit bad;
    bad = 1'b0;
    if (expected_words.size() == 0) begin
      $display("%0t: unexpected result word, expected none, got %p", $time, out_m.payload_word);
      fail_count++;
      return;
    end
    e = expected_words.pop_front();
    check_field("is_packet", 64'(e.is_packet), 64'(out_m.is_packet), bad);
    check_field("flag_text", 64'(e.flag_text), 64'(out_m.flag_text), bad);
    check_field("flag_end", 64'(e.flag_end), 64'(out_m.flag_end), bad);
    check_field("flag_read_error", 64'(e.flag_read_error), 64'(out_m.flag_read_error), bad);
    check_field("packet_seq", 64'(e.packet_seq), 64'(out_m.packet_seq), bad);
    check_field("chunk_number", 64'(e.chunk_number), 64'(out_m.chunk_number), bad);
    check_field("payload_bytes", 64'(e.payload_bytes), 64'(out_m.payload_bytes), bad);
    check_field("word_number", 64'(e.word_number), 64'(out_m.word_number), bad);
    check_field("payload_word", e.payload_word, out_m.payload_word, bad);
    check_field("frame_consumed", 64'(e.frame_consumed), 64'(out_m.frame_consumed), bad);
    check_field("read_requested", 64'(e.read_requested), 64'(out_m.read_requested), bad);
    check_field("last", 64'(e.last), 64'(out_m.last), bad);
    if (bad) fail_count++;
    words_checked++;
  endtask

  initial begin
    fail_count = 0;
    words_waiting = 0;
    words_checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      base_id     = BASE_ID_RST;
      end_id      = END_ID_RST;
      timeout_lim = TIMEOUT_RST;
      clear_text(1'b1);
      seq_cnt   = '0;
      req_cnt   = '0;
      ring_cnt  = '0;
      ring_head = '0;
      ring_tail = '0;
      expected_words.delete();
    end else begin
      if (cfg_we)
        case (cfg_index)
          REG_BASE_ID: base_id = cfg_data[10:0];
          REG_END_ID:  end_id = cfg_data[10:0];
          REG_TIMEOUT: timeout_lim = cfg_data;
          default: ;
        endcase
      if (in_m.valid && in_m.ready)
        predict_word(cmd_t'(in_m.cmd), in_m.frame_id, in_m.frame_data, in_m.now_ms);
      if (out_m.valid && out_m.ready) compare_word();
    end
    words_waiting = expected_words.size();
  end

endmodule

[bench/text_frame_reassembly_read_tracker_unit_tb.sv]
// Testbench top for the text frame reassembly and read tracker: clock, reset,
// stimulus, register writes and verdict. Depends on tfrrt_pkg, both channel
// interfaces, tfrrt_checker and the unit itself.
module text_frame_reassembly_read_tracker_unit_tb;
  import tfrrt_pkg::*;

  localparam int CYCLE_LIMIT = 1000000;

  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;
  int          fail_count, words_waiting, words_checked;
  int          cycles, words_sent;
  logic [10:0] base_id, end_id;
  logic [31:0] now_ms;

  tfrrt_in_if  in_ch();
  tfrrt_out_if out_ch();

  text_frame_reassembly_read_tracker_unit DUT (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  tfrrt_checker u_checker (
    .clk(clk), .rst_n(rst_n), .in_m(in_ch), .out_m(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .fail_count(fail_count), .words_waiting(words_waiting), .words_checked(words_checked)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("text_frame_reassembly_read_tracker_unit_tb failed");
      $finish;
    end
  end

  // receiver: stall pattern drawn at random among four, one long hold-off
  initial begin
    int mode, hold;
    bit held;
    held = 1'b0;
    out_ch.ready = 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (!held && words_sent >= 120) begin
        held = 1'b1;
        out_ch.ready <= 1'b0;
        for (hold = 0; hold < 400; hold++) @(posedge clk);
      end
      if (cycles % 64 == 0) mode = $urandom_range(0, 3);
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 1) == 1);
        2: out_ch.ready <= ($urandom_range(0, 7) == 0);
        default: out_ch.ready <= ((cycles % 5) != 0);
      endcase
    end
  end

  int burst_left;
  bit gapless;

  task automatic put_word(input cmd_t cmd, input logic [10:0] fid,
                          input logic [63:0] fdata, input logic [31:0] now);
    if (burst_left == 0) begin
      in_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = $urandom_range(1, 10);
    end
    in_ch.valid      <= 1'b1;
    in_ch.cmd        <= cmd;
    in_ch.frame_id   <= fid;
    in_ch.frame_data <= fdata;
    in_ch.now_ms     <= now;
    do @(posedge clk); while (!in_ch.ready);
    words_sent++;
    if (!gapless) burst_left--;
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (words_waiting != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_BASE_ID) base_id = val[10:0];
    if (idx == REG_END_ID) end_id = val[10:0];
  endtask

  function automatic logic [63:0] text_bytes();
    logic [63:0] d;
    d = {$urandom, $urandom};
    case ($urandom_range(0, 5))
      0: d = '0;
      1, 2: d = d >> (8 * $urandom_range(1, 7));
      3: d = d & 64'h00FF_00FF_00FF_00FF;
      default: ;
    endcase
    return d;
  endfunction

  task automatic text_frame(input int slot);
    put_word(CMD_FRAME, base_id + 11'(slot), text_bytes(), now_ms);
  endtask

  task automatic tick(input int lo, input int hi);
    now_ms += $urandom_range(lo, hi);
  endtask

  task automatic transfer();
    int nf;
    if ($urandom_range(0, 2) == 0)
      put_word(CMD_READ_REQ, 11'($urandom), {$urandom, $urandom}, now_ms);
    if ($urandom_range(0, 2) == 0)
      put_word(CMD_SEND, 11'($urandom), {$urandom, $urandom}, now_ms);
    nf = $urandom_range(1, 9);
    for (int i = 0; i < nf; i++) begin
      if ($urandom_range(0, 3) != 0) text_frame(i % 4);
      else text_frame($urandom_range(0, 3));
      tick(0, 20);
    end
    if ($urandom_range(0, 3) != 0) put_word(CMD_FRAME, end_id, text_bytes(), now_ms);
  endtask

  task automatic random_word();
    case ($urandom_range(0, 9))
      0, 1: put_word(CMD_FRAME, 11'($urandom), {$urandom, $urandom}, $urandom);
      2, 3: put_word(CMD_READ_REQ, 11'($urandom), {$urandom, $urandom}, now_ms);
      4, 5: put_word(CMD_SEND, 11'($urandom), {$urandom, $urandom}, now_ms);
      6: begin
        tick(0, 3 * 65536);
        put_word(CMD_TIMEOUT, 11'($urandom), {$urandom, $urandom}, now_ms);
      end
      7: put_word(CMD_FRAME, end_id, text_bytes(), now_ms);
      default: transfer();
    endcase
  endtask

  task automatic fill_tracking();
    for (int i = 0; i < 34; i++) put_word(CMD_READ_REQ, '0, '1, now_ms);
    for (int i = 0; i < 34; i++) begin
      tick(0, 5);
      put_word(CMD_SEND, '1, '0, now_ms);
      if (i == 31) for (int j = 0; j < 3; j++) put_word(CMD_READ_REQ, '0, '0, now_ms);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    cycles = 0;
    words_sent = 0;
    burst_left = 4;
    gapless = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_FRAME;
    in_ch.frame_id = '0;
    in_ch.frame_data = '0;
    in_ch.now_ms = '0;
    base_id = BASE_ID_RST;
    end_id = END_ID_RST;
    now_ms = 32'hFFFF_F000;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty end, full/gapped/trimmed text, foreign id, timeout across the wrap
    put_word(CMD_FRAME, end_id, '0, now_ms);
    put_word(CMD_FRAME, base_id, '1, now_ms);
    put_word(CMD_FRAME, base_id + 11'd1, 64'h8000_0000_0000_0001, now_ms);
    put_word(CMD_FRAME, base_id + 11'd2, '1, now_ms);
    put_word(CMD_FRAME, base_id + 11'd3, 64'h0000_0000_00AB_0000, now_ms);
    put_word(CMD_FRAME, base_id, 64'h11, now_ms);
    put_word(CMD_FRAME, base_id + 11'd2, 64'h22, now_ms);
    put_word(CMD_FRAME, end_id, 64'h33, now_ms);
    put_word(CMD_FRAME, base_id + 11'd1, '1, now_ms);
    put_word(CMD_FRAME, end_id, '0, now_ms);
    put_word(CMD_FRAME, base_id, '0, now_ms);
    put_word(CMD_FRAME, end_id, '0, now_ms);
    put_word(CMD_FRAME, 11'h7FF, '1, now_ms);
    put_word(CMD_SEND, '0, '0, now_ms);
    put_word(CMD_READ_REQ, '0, '0, now_ms);
    put_word(CMD_SEND, '0, '0, now_ms);
    put_word(CMD_TIMEOUT, '0, '0, now_ms + 32'd5000);
    put_word(CMD_TIMEOUT, '0, '0, now_ms + 32'd5001);
    put_word(CMD_TIMEOUT, '1, '1, 32'hFFFF_FFFF);
    drain();

    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        1: begin
          write_reg(REG_BASE_ID, 16'd0);
          write_reg(REG_END_ID, 16'h07FF);
          write_reg(REG_TIMEOUT, 16'd0);
        end
        2: begin
          write_reg(REG_BASE_ID, 16'h07FF);
          write_reg(REG_END_ID, 16'd0);
          write_reg(REG_TIMEOUT, 16'hFFFF);
        end
        3: begin
          write_reg(REG_BASE_ID, 16'h0100);
          write_reg(REG_END_ID, 16'h0102);
          write_reg(REG_TIMEOUT, 16'd100);
        end
        4: begin
          write_reg(REG_BASE_ID, 16'h0220);
          write_reg(REG_END_ID, 16'h07FE);
          write_reg(REG_TIMEOUT, 16'd5000);
        end
        default: ;
      endcase
      gapless = (phase == 2);
      if (phase == 0) fill_tracking();
      while (words_sent < 60 * (phase + 1) + 20) random_word();
      drain();
    end

    $display("sent %0d words over five register settings, %0d result words checked",
             words_sent, words_checked);
    if (fail_count == 0) begin
      $display("text_frame_reassembly_read_tracker_unit_tb passed");
    end else begin
      $display("text_frame_reassembly_read_tracker_unit_tb failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/tfrrt_pkg.sv
rtl/tfrrt_in_if.sv
rtl/tfrrt_out_if.sv
rtl/tfrrt_ring.sv
rtl/text_frame_reassembly_read_tracker_unit.sv
bench/tfrrt_checker.sv
bench/text_frame_reassembly_read_tracker_unit_tb.sv
